>>> rtl/flc_pkg.sv
`default_nettype none
package flc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    // window pull-in applied when an edge register is written or reset
    localparam logic [31:0] HALF_IN    = 32'h0000_8000;
    localparam logic [31:0] HALF_IN_RB = 32'h0000_8001;

    localparam logic [31:0] CLIP_LEFT_RST   = 32'd0;
    localparam logic [31:0] CLIP_RIGHT_RST  = 32'd41877504;
    localparam logic [31:0] CLIP_TOP_RST    = 32'd0;
    localparam logic [31:0] CLIP_BOTTOM_RST = 32'd31391744;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_TOP    = 2'd2;
    localparam logic [1:0] CFG_BOTTOM = 2'd3;

    localparam logic [3:0] OC_NONE   = 4'b0000;
    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_TOP    = 4'b0100;
    localparam logic [3:0] OC_BOTTOM = 4'b1000;

    typedef enum logic [1:0] {
        ST_UNCLIPPED = 2'd0,
        ST_CLIPPED   = 2'd1,
        ST_REJECTED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_ONE   = 2'd1,
        MODE_THREE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CLS_PASS   = 2'd0,
        CLS_REJECT = 2'd1,
        CLS_CLIP   = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        F_X = 3'd0,
        F_Y = 3'd1,
        F_A = 3'd2,
        F_B = 3'd3,
        F_C = 3'd4
    } field_t;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_PICK  = 3'd1,
        BK_SETUP = 3'd2,
        BK_ISSUE = 3'd3,
        BK_WAIT  = 3'd4,
        BK_FIN   = 3'd5,
        BK_OUT   = 3'd6
    } back_state_t;

    typedef enum logic [2:0] {
        MD_IDLE = 3'd0,
        MD_MUL  = 3'd1,
        MD_ABS  = 3'd2,
        MD_DIV  = 3'd3,
        MD_DONE = 3'd4
    } md_state_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } vtx_t;

    typedef struct packed {
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        logic [31:0] b;
    } edges_t;

    typedef struct packed {
        cls_t       cls;
        mode_t      mode;
        logic [3:0] c0;
        logic [3:0] c1;
        vtx_t       sv;
        vtx_t       ev;
    } item_t;

    typedef struct packed {
        status_t status;
        vtx_t    sv;
        vtx_t    ev;
    } result_t;

    function automatic logic [3:0] code_lr(logic [31:0] x, edges_t e);
        logic [3:0] c;
        c = OC_NONE;
        if ($signed(x) < $signed(e.l))
            c = OC_LEFT;
        else if ($signed(x) > $signed(e.r))
            c = OC_RIGHT;
        return c;
    endfunction

    function automatic logic [3:0] code_tb(logic [31:0] y, edges_t e);
        logic [3:0] c;
        c = OC_NONE;
        if ($signed(y) < $signed(e.t))
            c = OC_TOP;
        else if ($signed(y) > $signed(e.b))
            c = OC_BOTTOM;
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/flc_front.sv
`default_nettype none
module flc_front (
    input  wire flc_pkg::edges_t edges,
    input  wire flc_pkg::vtx_t   sv,
    input  wire flc_pkg::vtx_t   ev,
    input  wire logic [1:0]      attr_mode,
    output flc_pkg::item_t       item
);

    logic [3:0] c0;
    logic [3:0] c1;

    assign c0 = flc_pkg::code_lr(sv.x, edges) | flc_pkg::code_tb(sv.y, edges);
    assign c1 = flc_pkg::code_lr(ev.x, edges) | flc_pkg::code_tb(ev.y, edges);

    always_comb
    begin
        item.sv = sv;
        item.ev = ev;
        item.c0 = c0;
        item.c1 = c1;
        case (attr_mode)
            flc_pkg::MODE_ONE:   item.mode = flc_pkg::MODE_ONE;
            flc_pkg::MODE_THREE: item.mode = flc_pkg::MODE_THREE;
            default:             item.mode = flc_pkg::MODE_NONE;
        endcase
        if ((c0 & c1) != flc_pkg::OC_NONE)
            item.cls = flc_pkg::CLS_REJECT;
        else if ((c0 | c1) == flc_pkg::OC_NONE)
            item.cls = flc_pkg::CLS_PASS;
        else
            item.cls = flc_pkg::CLS_CLIP;
    end

endmodule
`default_nettype wire

>>> rtl/flc_queue.sv
`default_nettype none
module flc_queue #(
    parameter int unsigned DEPTH = flc_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire flc_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output flc_pkg::item_t      pop_item,
    output logic                empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    flc_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

>>> rtl/flc_muldiv.sv
`default_nettype none
module flc_muldiv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] d,
    output logic             done,
    output logic [31:0]      q
);

    flc_pkg::md_state_t state_reg, state_next;

    logic [31:0]        a_reg, b_reg, d_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        num_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               neg_reg, zero_reg;
    logic [5:0]         cnt_reg;
    logic signed [63:0] prod;
    logic [32:0]        shifted;
    logic               ge;

    assign prod    = $signed(a_reg) * $signed(b_reg);
    assign shifted = {rem_reg, num_reg[63]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            flc_pkg::MD_IDLE: if (start) state_next = flc_pkg::MD_MUL;
            flc_pkg::MD_MUL:  state_next = flc_pkg::MD_ABS;
            flc_pkg::MD_ABS:  state_next = flc_pkg::MD_DIV;
            flc_pkg::MD_DIV:  if (cnt_reg == 6'd63) state_next = flc_pkg::MD_DONE;
            flc_pkg::MD_DONE: state_next = flc_pkg::MD_IDLE;
            default:          state_next = flc_pkg::MD_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == flc_pkg::MD_DONE);
        if (zero_reg)
            q = '0;
        else if (neg_reg)
            q = -num_reg[31:0];
        else
            q = num_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= flc_pkg::MD_IDLE;
        else
            state_reg <= state_next;
    end

    // restoring division of magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            flc_pkg::MD_IDLE:
            begin
                a_reg <= a;
                b_reg <= b;
                d_reg <= d;
            end
            flc_pkg::MD_MUL:
                prod_reg <= prod;
            flc_pkg::MD_ABS:
            begin
                num_reg  <= prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
                den_reg  <= d_reg[31] ? -d_reg : d_reg;
                neg_reg  <= prod_reg[63] ^ d_reg[31];
                zero_reg <= (d_reg == '0);
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            flc_pkg::MD_DIV:
            begin
                rem_reg <= ge ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
                num_reg <= {num_reg[62:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/flc_back.sv
`default_nettype none
module flc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire flc_pkg::edges_t edges,
    input  wire logic            q_empty,
    input  wire flc_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 res_valid,
    output flc_pkg::result_t     res,
    input  wire logic            res_pop
);

    flc_pkg::back_state_t state_reg, state_next;

    flc_pkg::vtx_t    sv_reg, sv_next;
    flc_pkg::vtx_t    ev_reg, ev_next;
    flc_pkg::mode_t   mode_reg, mode_next;
    logic [3:0]       c1_reg, c1_next;
    logic [3:0]       code_reg, code_next;
    logic             side_reg, side_next;
    logic             ydone_reg, ydone_next;
    logic             axis_y_reg, axis_y_next;
    logic             rej_reg, rej_next;
    logic [31:0]      edge_reg, edge_next;
    logic [31:0]      delta_reg, delta_next;
    logic [31:0]      d_reg, d_next;
    flc_pkg::field_t  field_reg, field_next;
    logic             out_valid_reg, out_valid_next;
    flc_pkg::result_t out_reg, out_next;

    flc_pkg::vtx_t p, qv, p_upd;
    logic          out_free;
    logic          md_start, md_done;
    logic [31:0]   md_a, md_q;

    function automatic logic [31:0] vget(flc_pkg::vtx_t v, flc_pkg::field_t f);
        case (f)
            flc_pkg::F_X: return v.x;
            flc_pkg::F_Y: return v.y;
            flc_pkg::F_A: return v.a;
            flc_pkg::F_B: return v.b;
            flc_pkg::F_C: return v.c;
            default:      return '0;
        endcase
    endfunction

    function automatic flc_pkg::vtx_t vset(flc_pkg::vtx_t v, flc_pkg::field_t f,
                                           logic [31:0] val);
        flc_pkg::vtx_t r;
        r = v;
        case (f)
            flc_pkg::F_X: r.x = val;
            flc_pkg::F_Y: r.y = val;
            flc_pkg::F_A: r.a = val;
            flc_pkg::F_B: r.b = val;
            flc_pkg::F_C: r.c = val;
            default:      r = v;
        endcase
        return r;
    endfunction

    assign p         = side_reg ? ev_reg : sv_reg;
    assign qv        = side_reg ? sv_reg : ev_reg;
    assign out_free  = !out_valid_reg || res_pop;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign md_a      = vget(qv, field_reg) - vget(p, field_reg);
    assign md_start  = (state_reg == flc_pkg::BK_ISSUE);

    flc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (delta_reg),
        .d     (d_reg),
        .done  (md_done),
        .q     (md_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            flc_pkg::BK_IDLE:
                if (!q_empty && out_free && q_item.cls == flc_pkg::CLS_CLIP)
                    state_next = flc_pkg::BK_PICK;
            flc_pkg::BK_PICK:
                if (ydone_reg)
                begin
                    if (code_reg != flc_pkg::OC_NONE || side_reg)
                        state_next = flc_pkg::BK_OUT;
                end
                else if ((code_reg & (flc_pkg::OC_LEFT | flc_pkg::OC_RIGHT |
                                      flc_pkg::OC_TOP | flc_pkg::OC_BOTTOM)) != '0)
                    state_next = flc_pkg::BK_SETUP;
                else if (side_reg)
                    state_next = flc_pkg::BK_OUT;
            flc_pkg::BK_SETUP:
                state_next = flc_pkg::BK_ISSUE;
            flc_pkg::BK_ISSUE:
                state_next = flc_pkg::BK_WAIT;
            flc_pkg::BK_WAIT:
                if (md_done)
                begin
                    if (field_next != field_reg)
                        state_next = flc_pkg::BK_ISSUE;
                    else
                        state_next = flc_pkg::BK_FIN;
                end
            flc_pkg::BK_FIN:
                state_next = flc_pkg::BK_PICK;
            flc_pkg::BK_OUT:
                if (out_free)
                    state_next = flc_pkg::BK_IDLE;
            default:
                state_next = flc_pkg::BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sv_next        = sv_reg;
        ev_next        = ev_reg;
        mode_next      = mode_reg;
        c1_next        = c1_reg;
        code_next      = code_reg;
        side_next      = side_reg;
        ydone_next     = ydone_reg;
        axis_y_next    = axis_y_reg;
        rej_next       = rej_reg;
        edge_next      = edge_reg;
        delta_next     = delta_reg;
        d_next         = d_reg;
        field_next     = field_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_pop;
        q_pop          = 1'b0;
        p_upd          = p;

        case (state_reg)
            flc_pkg::BK_IDLE:
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_item.cls)
                        flc_pkg::CLS_PASS:
                        begin
                            out_valid_next = 1'b1;
                            out_next.status = flc_pkg::ST_UNCLIPPED;
                            out_next.sv = q_item.sv;
                            out_next.ev = q_item.ev;
                        end
                        flc_pkg::CLS_CLIP:
                        begin
                            sv_next    = q_item.sv;
                            ev_next    = q_item.ev;
                            mode_next  = q_item.mode;
                            c1_next    = q_item.c1;
                            code_next  = q_item.c0;
                            side_next  = 1'b0;
                            ydone_next = 1'b0;
                            rej_next   = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next = '0;
                            out_next.status = flc_pkg::ST_REJECTED;
                        end
                    endcase
                end
            flc_pkg::BK_PICK:
            begin
                if (ydone_reg && code_reg != flc_pkg::OC_NONE)
                    rej_next = 1'b1;
                else if (!ydone_reg && (code_reg & (flc_pkg::OC_LEFT | flc_pkg::OC_RIGHT)) != '0)
                begin
                    axis_y_next = 1'b0;
                    edge_next   = (code_reg & flc_pkg::OC_LEFT) != '0 ? edges.l : edges.r;
                end
                else if (!ydone_reg && (code_reg & (flc_pkg::OC_TOP | flc_pkg::OC_BOTTOM)) != '0)
                begin
                    axis_y_next = 1'b1;
                    edge_next   = (code_reg & flc_pkg::OC_TOP) != '0 ? edges.t : edges.b;
                end
                else if (!side_reg)
                begin
                    // start endpoint finished: move on to the end endpoint
                    side_next  = 1'b1;
                    code_next  = c1_reg;
                    ydone_next = 1'b0;
                end
            end
            flc_pkg::BK_SETUP:
                if (axis_y_reg)
                begin
                    d_next     = qv.y - p.y;
                    delta_next = edge_reg - p.y;
                    field_next = flc_pkg::F_X;
                end
                else
                begin
                    d_next     = qv.x - p.x;
                    delta_next = edge_reg - p.x;
                    field_next = flc_pkg::F_Y;
                end
            flc_pkg::BK_WAIT:
                if (md_done)
                begin
                    p_upd = vset(p, field_reg, vget(p, field_reg) + md_q);
                    if (side_reg)
                        ev_next = p_upd;
                    else
                        sv_next = p_upd;
                    case (field_reg)
                        flc_pkg::F_A:
                            if (mode_reg == flc_pkg::MODE_THREE)
                                field_next = flc_pkg::F_B;
                        flc_pkg::F_B:
                            field_next = flc_pkg::F_C;
                        flc_pkg::F_C:
                            field_next = flc_pkg::F_C;
                        default:
                            if (mode_reg != flc_pkg::MODE_NONE)
                                field_next = flc_pkg::F_A;
                    endcase
                end
            flc_pkg::BK_FIN:
            begin
                p_upd = vset(p, axis_y_reg ? flc_pkg::F_Y : flc_pkg::F_X, edge_reg);
                if (side_reg)
                    ev_next = p_upd;
                else
                    sv_next = p_upd;
                if (axis_y_reg)
                begin
                    code_next  = flc_pkg::code_lr(p.x, edges);
                    ydone_next = 1'b1;
                end
                else
                    code_next = flc_pkg::code_tb(p.y, edges);
            end
            flc_pkg::BK_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (rej_reg)
                    begin
                        out_next = '0;
                        out_next.status = flc_pkg::ST_REJECTED;
                    end
                    else
                    begin
                        out_next.status = flc_pkg::ST_CLIPPED;
                        out_next.sv = sv_reg;
                        out_next.ev = ev_reg;
                    end
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flc_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sv_reg     <= sv_next;
        ev_reg     <= ev_next;
        mode_reg   <= mode_next;
        c1_reg     <= c1_next;
        code_reg   <= code_next;
        side_reg   <= side_next;
        ydone_reg  <= ydone_next;
        axis_y_reg <= axis_y_next;
        rej_reg    <= rej_next;
        edge_reg   <= edge_next;
        delta_reg  <= delta_next;
        d_reg      <= d_next;
        field_reg  <= field_next;
        out_reg    <= out_next;
    end

endmodule
`default_nettype wire

>>> rtl/fixed_point_line_clipper.sv
// Flow: a trivially accepted or rejected segment goes through the queue and then the result
//   register; a clipped one, once the back end takes it, runs S clip steps (1 to 4) with
//   N divides per step (1, 2 or 4 by attr_mode), each divide run on the shared bit-serial
//   64/32 divider at one quotient bit per cycle.
// Throughput: one trivial segment per cycle while results are popped each cycle; a clipped segment holds the back end.
// Reset: async active low; queue and result register empty, window registers back to their defaults.
`default_nettype none
module fixed_point_line_clipper #(
    parameter int unsigned QUEUE_DEPTH = flc_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input beats
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] start_x,
    input  wire logic [31:0] start_y,
    input  wire logic [31:0] end_x,
    input  wire logic [31:0] end_y,
    input  wire logic [31:0] start_attr_a,
    input  wire logic [31:0] start_attr_b,
    input  wire logic [31:0] start_attr_c,
    input  wire logic [31:0] end_attr_a,
    input  wire logic [31:0] end_attr_b,
    input  wire logic [31:0] end_attr_c,
    input  wire logic [1:0]  attr_mode,
    // result beats
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       status,
    output logic [31:0]      out_start_x,
    output logic [31:0]      out_start_y,
    output logic [31:0]      out_end_x,
    output logic [31:0]      out_end_y,
    output logic [31:0]      out_start_attr_a,
    output logic [31:0]      out_start_attr_b,
    output logic [31:0]      out_start_attr_c,
    output logic [31:0]      out_end_attr_a,
    output logic [31:0]      out_end_attr_b,
    output logic [31:0]      out_end_attr_c,
    // window registers
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Edges are kept already pulled in, so the outcode compares see
    // no subtract in front of them.
    flc_pkg::edges_t  edges_reg;
    flc_pkg::vtx_t    in_sv, in_ev;
    flc_pkg::item_t   front_item, q_item;
    flc_pkg::result_t res;
    logic             q_empty, q_pop, res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edges_reg.l <= flc_pkg::CLIP_LEFT_RST   - flc_pkg::HALF_IN;
            edges_reg.r <= flc_pkg::CLIP_RIGHT_RST  - flc_pkg::HALF_IN_RB;
            edges_reg.t <= flc_pkg::CLIP_TOP_RST    - flc_pkg::HALF_IN;
            edges_reg.b <= flc_pkg::CLIP_BOTTOM_RST - flc_pkg::HALF_IN_RB;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                flc_pkg::CFG_LEFT:   edges_reg.l <= cfg_data - flc_pkg::HALF_IN;
                flc_pkg::CFG_RIGHT:  edges_reg.r <= cfg_data - flc_pkg::HALF_IN_RB;
                flc_pkg::CFG_TOP:    edges_reg.t <= cfg_data - flc_pkg::HALF_IN;
                flc_pkg::CFG_BOTTOM: edges_reg.b <= cfg_data - flc_pkg::HALF_IN_RB;
                default:             edges_reg <= edges_reg;
            endcase
        end
    end

    assign in_sv = '{x: start_x, y: start_y, a: start_attr_a, b: start_attr_b, c: start_attr_c};
    assign in_ev = '{x: end_x, y: end_y, a: end_attr_a, b: end_attr_b, c: end_attr_c};

    // front: outcodes and trivial accept/reject
    flc_front u_front (
        .edges     (edges_reg),
        .sv        (in_sv),
        .ev        (in_ev),
        .attr_mode (attr_mode),
        .item      (front_item)
    );

    // decoupling queue between classify and clip
    flc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    // back: clip sequencer with shared multiply/divide and result register
    flc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .edges     (edges_reg),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    assign empty            = !res_valid;
    assign status           = res.status;
    assign out_start_x      = res.sv.x;
    assign out_start_y      = res.sv.y;
    assign out_end_x        = res.ev.x;
    assign out_end_y        = res.ev.y;
    assign out_start_attr_a = res.sv.a;
    assign out_start_attr_b = res.sv.b;
    assign out_start_attr_c = res.sv.c;
    assign out_end_attr_a   = res.ev.a;
    assign out_end_attr_b   = res.ev.b;
    assign out_end_attr_c   = res.ev.c;

endmodule
`default_nettype wire

>>> rtl/flc_checker.sv
`default_nettype none
module flc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  status,
    input wire logic [31:0] out_start_x,
    input wire logic [31:0] out_start_y,
    input wire logic [31:0] out_end_x,
    input wire logic [31:0] out_end_y,
    input wire logic [31:0] out_start_attr_a,
    input wire logic [31:0] out_start_attr_b,
    input wire logic [31:0] out_start_attr_c,
    input wire logic [31:0] out_end_attr_a,
    input wire logic [31:0] out_end_attr_b,
    input wire logic [31:0] out_end_attr_c
);

    a_reset_clean: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not empty in reset");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == flc_pkg::ST_UNCLIPPED || status == flc_pkg::ST_CLIPPED ||
                    status == flc_pkg::ST_REJECTED))
        else $error("illegal status");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == flc_pkg::ST_REJECTED |->
            out_start_x == '0 && out_start_y == '0 && out_end_x == '0 && out_end_y == '0 &&
            out_start_attr_a == '0 && out_start_attr_b == '0 && out_start_attr_c == '0 &&
            out_end_attr_a == '0 && out_end_attr_b == '0 && out_end_attr_c == '0)
        else $error("rejected beat carries data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(out_start_x) &&
            $stable(out_end_y) && $stable(out_end_attr_c))
        else $error("result changed while waiting");

endmodule

bind fixed_point_line_clipper flc_checker u_flc_checker (.*);
`default_nettype wire

>>> dv/tb_fixed_point_line_clipper.sv
`timescale 1ns / 1ps
module tb_fixed_point_line_clipper;

    // One segment as presented on the push side.
    typedef struct {
        logic [31:0] sx, sy, ex, ey;
        logic [31:0] sa, sb, sc, ea, eb, ec;
        logic [1:0]  mode;
    } segment_t;

    // One result beat as seen on the pop side.
    typedef struct {
        logic [1:0]  st;
        logic [31:0] f[10];
    } clip_out_t;

    localparam int LIMIT = 8_000_000;

    logic clk, rst_n;
    logic push, pop, full, empty;
    logic [31:0] start_x, start_y, end_x, end_y;
    logic [31:0] start_attr_a, start_attr_b, start_attr_c;
    logic [31:0] end_attr_a, end_attr_b, end_attr_c;
    logic [1:0]  attr_mode;
    logic [1:0]  status;
    logic [31:0] out_start_x, out_start_y, out_end_x, out_end_y;
    logic [31:0] out_start_attr_a, out_start_attr_b, out_start_attr_c;
    logic [31:0] out_end_attr_a, out_end_attr_b, out_end_attr_c;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    fixed_point_line_clipper u_top (.*);

    // Window as the predictor sees it (raw register values).
    logic [31:0] win_l, win_r, win_t, win_b;
    // Pulled-in edges used during one prediction.
    logic [31:0] e_l, e_r, e_t, e_b;
    logic [1:0]  cur_mode;

    segment_t  pending_segs[$];
    clip_out_t expected_clips[$];
    int        n_fail = 0, n_popped = 0, n_clipped = 0, n_rejected = 0;
    longint    cycle = 0;
    bit        sender_on = 0, calm = 0, stim_done = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle <= cycle + 1;

    // Scale (b-a)*delta/d, 64-bit product, truncate toward zero, wrap to 32.
    function automatic logic [31:0] scale(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        longint p, d;
        p = longint'($signed(a)) * longint'($signed(b));
        d = longint'($signed(c));
        if (d == 0)
            return 32'd0;
        return 32'(p / d);
    endfunction

    function automatic logic [3:0] lr_code(logic [31:0] x);
        if ($signed(x) < $signed(e_l)) return flc_pkg::OC_LEFT;
        if ($signed(x) > $signed(e_r)) return flc_pkg::OC_RIGHT;
        return flc_pkg::OC_NONE;
    endfunction

    function automatic logic [3:0] tb_code(logic [31:0] y);
        if ($signed(y) < $signed(e_t)) return flc_pkg::OC_TOP;
        if ($signed(y) > $signed(e_b)) return flc_pkg::OC_BOTTOM;
        return flc_pkg::OC_NONE;
    endfunction

    function automatic void slide_attrs(ref flc_pkg::vtx_t p, input flc_pkg::vtx_t q,
                                        input logic [31:0] delta, input logic [31:0] d);
        if (cur_mode == flc_pkg::MODE_ONE)
            p.a = p.a + scale(q.a - p.a, delta, d);
        else if (cur_mode == flc_pkg::MODE_THREE)
        begin
            p.a = p.a + scale(q.a - p.a, delta, d);
            p.b = p.b + scale(q.b - p.b, delta, d);
            p.c = p.c + scale(q.c - p.c, delta, d);
        end
    endfunction

    // Move p onto a vertical edge, return its new top/bottom code.
    function automatic logic [3:0] onto_x(ref flc_pkg::vtx_t p, input flc_pkg::vtx_t q,
                                          input logic [31:0] e);
        logic [31:0] d, delta;
        d = q.x - p.x;
        delta = e - p.x;
        p.x = e;
        p.y = p.y + scale(q.y - p.y, delta, d);
        slide_attrs(p, q, delta, d);
        return tb_code(p.y);
    endfunction

    function automatic logic [3:0] onto_y(ref flc_pkg::vtx_t p, input flc_pkg::vtx_t q,
                                          input logic [31:0] e);
        logic [31:0] d, delta;
        d = q.y - p.y;
        delta = e - p.y;
        p.y = e;
        p.x = p.x + scale(q.x - p.x, delta, d);
        slide_attrs(p, q, delta, d);
        return lr_code(p.x);
    endfunction

    function automatic logic [3:0] pull_in(ref flc_pkg::vtx_t p, input flc_pkg::vtx_t q,
                                           input logic [3:0] code);
        if (code & flc_pkg::OC_LEFT) code = onto_x(p, q, e_l);
        else if (code & flc_pkg::OC_RIGHT) code = onto_x(p, q, e_r);
        if (code & flc_pkg::OC_TOP) code = onto_y(p, q, e_t);
        else if (code & flc_pkg::OC_BOTTOM) code = onto_y(p, q, e_b);
        return code;
    endfunction

    function automatic clip_out_t clip_segment(segment_t g);
        clip_out_t r;
        flc_pkg::vtx_t s, e;
        logic [3:0] c0, c1;
        s = '{g.sx, g.sy, g.sa, g.sb, g.sc};
        e = '{g.ex, g.ey, g.ea, g.eb, g.ec};
        // the unused mode code behaves as no attributes
        cur_mode = (g.mode == 2'd3) ? flc_pkg::MODE_NONE : g.mode;
        e_l = win_l - flc_pkg::HALF_IN;
        e_r = win_r - flc_pkg::HALF_IN_RB;
        e_t = win_t - flc_pkg::HALF_IN;
        e_b = win_b - flc_pkg::HALF_IN_RB;
        r.st = flc_pkg::ST_REJECTED;
        foreach (r.f[i]) r.f[i] = '0;
        c0 = lr_code(s.x) | tb_code(s.y);
        c1 = lr_code(e.x) | tb_code(e.y);
        if ((c0 & c1) != 0)
            return r;
        if ((c0 | c1) == 0)
            r.st = flc_pkg::ST_UNCLIPPED;
        else
        begin
            if (c0 != 0 && pull_in(s, e, c0) != 0) return r;
            if (c1 != 0 && pull_in(e, s, c1) != 0) return r;
            r.st = flc_pkg::ST_CLIPPED;
        end
        r.f = '{s.x, s.y, e.x, e.y, s.a, s.b, s.c, e.a, e.b, e.c};
        return r;
    endfunction

    // Idle with a chance of 24 in 100, except in the calm stretch.
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 24);
    endfunction

    function automatic string field_name(int i);
        string names[10] = '{"out_start_x", "out_start_y", "out_end_x", "out_end_y",
                             "out_start_attr_a", "out_start_attr_b", "out_start_attr_c",
                             "out_end_attr_a", "out_end_attr_b", "out_end_attr_c"};
        return names[i];
    endfunction

    // Driver: presents the head of the pending queue; a beat moves when push & !full.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            {start_x, start_y, end_x, end_y} <= '0;
            {start_attr_a, start_attr_b, start_attr_c} <= '0;
            {end_attr_a, end_attr_b, end_attr_c} <= '0;
            attr_mode <= '0;
        end
        else
        begin
            automatic bit took = push && !full;
            automatic segment_t g;
            if (took)
            begin
                expected_clips.push_back(clip_segment(pending_segs.pop_front()));
            end
            if ((took || !push) && pending_segs.size() > 0 && sender_on && !idle_now())
            begin
                g = pending_segs[0];
                push <= 1'b1;
                start_x <= g.sx; start_y <= g.sy; end_x <= g.ex; end_y <= g.ey;
                start_attr_a <= g.sa; start_attr_b <= g.sb; start_attr_c <= g.sc;
                end_attr_a <= g.ea; end_attr_b <= g.eb; end_attr_c <= g.ec;
                attr_mode <= g.mode;
            end
            else if (took || !push)
                push <= 1'b0;
        end
    end

    // Monitor: checks each popped beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            automatic clip_out_t x;
            automatic logic [31:0] got[10];
            if (pop && !empty)
            begin
                got = '{out_start_x, out_start_y, out_end_x, out_end_y,
                        out_start_attr_a, out_start_attr_b, out_start_attr_c,
                        out_end_attr_a, out_end_attr_b, out_end_attr_c};
                n_popped++;
                if (expected_clips.size() == 0)
                begin
                    $error("unexpected result beat, status %0d", status);
                    n_fail++;
                end
                else
                begin
                    x = expected_clips.pop_front();
                    if (x.st == flc_pkg::ST_CLIPPED) n_clipped++;
                    if (x.st == flc_pkg::ST_REJECTED) n_rejected++;
                    if (status !== x.st)
                    begin
                        $error("status: expected %0d, got %0d", x.st, status);
                        n_fail++;
                    end
                    foreach (got[i])
                        if (got[i] !== x.f[i])
                        begin
                            $error("%s: expected %h, got %h", field_name(i), x.f[i], got[i]);
                            n_fail++;
                        end
                end
            end
            pop <= !idle_now();
        end
    end

    // Window register write; block must be idle.
    task automatic set_window(logic [1:0] idx, logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            flc_pkg::CFG_LEFT:  win_l = v;
            flc_pkg::CFG_RIGHT: win_r = v;
            flc_pkg::CFG_TOP:   win_t = v;
            default:            win_b = v;
        endcase
    endtask

    // Let everything queued drain, plus some quiet cycles.
    task automatic drain();
        while (pending_segs.size() != 0 || push || expected_clips.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return {$urandom_range(1) ? 16'h8000 : 16'h7fff, 16'($urandom())};
            default: return 32'($signed($urandom_range(1400 << 16)) - (100 << 16));
        endcase
    endfunction

    function automatic segment_t rnd_seg();
        segment_t g;
        g.sx = rnd_coord(); g.sy = rnd_coord(); g.ex = rnd_coord(); g.ey = rnd_coord();
        g.sa = $urandom(); g.sb = $urandom(); g.sc = $urandom();
        g.ea = $urandom(); g.eb = $urandom(); g.ec = $urandom();
        g.mode = 2'($urandom_range(3));
        // share a coordinate now and then to hit zero divisors
        if ($urandom_range(9) == 0) g.ex = g.sx;
        if ($urandom_range(9) == 0) g.ey = g.sy;
        return g;
    endfunction

    function automatic segment_t mk(logic [31:0] sx, sy, ex, ey, logic [1:0] m);
        segment_t g;
        g = rnd_seg();
        g.sx = sx; g.sy = sy; g.ex = ex; g.ey = ey; g.mode = m;
        return g;
    endfunction

    initial
    begin
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        win_l = flc_pkg::CLIP_LEFT_RST; win_r = flc_pkg::CLIP_RIGHT_RST;
        win_t = flc_pkg::CLIP_TOP_RST; win_b = flc_pkg::CLIP_BOTTOM_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: trivial accept/reject, each mode incl. the unused code, zero divisor,
        // extreme coordinates, endpoint left outside after clipping.
        pending_segs.push_back(mk(32'h0010_0000, 32'h0010_0000, 32'h0100_0000, 32'h00f0_0000,
                                  flc_pkg::MODE_NONE));
        pending_segs.push_back(mk(32'hfff0_0000, 32'h0010_0000, 32'hffe0_0000, 32'h0100_0000,
                                  flc_pkg::MODE_NONE));
        pending_segs.push_back(mk(32'hfff0_0000, 32'h0010_0000, 32'h0100_0000, 32'h0100_0000,
                                  flc_pkg::MODE_ONE));
        pending_segs.push_back(mk(32'hfff0_0000, 32'hfff0_0000, 32'h0300_0000, 32'h0200_0000,
                                  flc_pkg::MODE_THREE));
        pending_segs.push_back(mk(32'hfff0_0000, 32'hfff0_0000, 32'h0300_0000, 32'h0200_0000,
                                  2'd3));
        pending_segs.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                  flc_pkg::MODE_THREE));
        pending_segs.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                  flc_pkg::MODE_ONE));
        pending_segs.push_back(mk(32'hffff_0000, 32'h0300_0000, 32'h0300_0000, 32'hffff_0000,
                                  flc_pkg::MODE_THREE));
        pending_segs.push_back(mk(32'h0000_7fff, 32'h0000_7fff, 32'h027f_7fff, 32'h01df_7fff,
                                  flc_pkg::MODE_THREE));
        pending_segs.push_back(mk(32'h0000_8000, 32'h0000_8000, 32'h027e_7fff, 32'h01dd_7fff,
                                  flc_pkg::MODE_NONE));
        pending_segs.push_back(mk(32'h0010_0000, 32'hfff0_0000, 32'h0010_0000, 32'h0300_0000,
                                  flc_pkg::MODE_THREE));
        pending_segs.push_back(mk(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000,
                                  flc_pkg::MODE_ONE));
        sender_on = 1;
        drain();

        // Random phases over several windows, extremes among them.
        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                1:
                begin
                    set_window(flc_pkg::CFG_LEFT, 32'h8000_0000);
                    set_window(flc_pkg::CFG_RIGHT, 32'h7fff_ffff);
                    set_window(flc_pkg::CFG_TOP, 32'h8000_0000);
                    set_window(flc_pkg::CFG_BOTTOM, 32'h7fff_ffff);
                end
                2:
                begin
                    set_window(flc_pkg::CFG_LEFT, 32'h0064_0000);
                    set_window(flc_pkg::CFG_RIGHT, 32'h0190_0000);
                    set_window(flc_pkg::CFG_TOP, 32'hffce_0000);
                    set_window(flc_pkg::CFG_BOTTOM, 32'h00c8_0000);
                end
                3:
                begin
                    set_window(flc_pkg::CFG_LEFT, $urandom());
                    set_window(flc_pkg::CFG_RIGHT, $urandom());
                    set_window(flc_pkg::CFG_TOP, $urandom());
                    set_window(flc_pkg::CFG_BOTTOM, $urandom());
                end
                4:
                begin
                    set_window(flc_pkg::CFG_LEFT, 32'h7fff_ffff);
                    set_window(flc_pkg::CFG_RIGHT, 32'h8000_0000);
                    set_window(flc_pkg::CFG_TOP, 32'h7fff_ffff);
                    set_window(flc_pkg::CFG_BOTTOM, 32'h8000_0000);
                end
                5:
                begin
                    set_window(flc_pkg::CFG_LEFT, flc_pkg::CLIP_LEFT_RST);
                    set_window(flc_pkg::CFG_RIGHT, flc_pkg::CLIP_RIGHT_RST);
                    set_window(flc_pkg::CFG_TOP, flc_pkg::CLIP_TOP_RST);
                    set_window(flc_pkg::CFG_BOTTOM, flc_pkg::CLIP_BOTTOM_RST);
                end
                default: ;
            endcase
            calm = (phase == 5);
            repeat (250) pending_segs.push_back(rnd_seg());
            drain();
        end
        calm = 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        $display("covered %0d beats (%0d clipped, %0d rejected) in directed cases and",
                 n_popped, n_clipped, n_rejected);
        $display("seven random phases over five windows, one phase with no idling");
        if (n_fail == 0 && expected_clips.size() == 0)
            $display("tb_fixed_point_line_clipper: PASS");
        else
            $display("tb_fixed_point_line_clipper: FAIL");
        $finish;
    end

    initial
    begin
        wait (cycle == LIMIT);
        $display("tb_fixed_point_line_clipper: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
rtl/flc_pkg.sv
rtl/flc_front.sv
rtl/flc_queue.sv
rtl/flc_muldiv.sv
rtl/flc_back.sv
rtl/fixed_point_line_clipper.sv
rtl/flc_checker.sv
dv/tb_fixed_point_line_clipper.sv
